@@ rtl/core/round_robin_group_task_queue_defines.svh @@
// Assertion macros for the round-robin group task queue.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ROUND_ROBIN_GROUP_TASK_QUEUE_DEFINES_SVH
`define ROUND_ROBIN_GROUP_TASK_QUEUE_DEFINES_SVH

// Plain invariant, checked at every clock edge out of reset.
`define RRGTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequence in the cycle after the trigger.
`define RRGTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rrgtq_pkg.sv @@
// Shared types and constants of the round-robin group task queue.
// No dependencies; imported by the interfaces and modules of the block.
`timescale 1ns / 1ps
`default_nettype none

package rrgtq_pkg;

  localparam int GROUPS_DEF   = 16;
  localparam int SLOTS_DEF    = 64;
  localparam int TAG_BITS_DEF = 32;

  localparam int GROUP_W   = 4;
  localparam int TASK_W    = 32;
  localparam int MAX_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [MAX_W-1:0] MAX_TASKS_RST = 6'd32;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } act_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_CLOSED = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_TASKS    = 2'd0,
    REG_QUEUE_CLOSED = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic tag_we;
    logic tag_re;
    logic nx_we;
    logic nx_re;
  } mem_ctl_t;

  typedef struct packed {
    logic q_empty;
    logic pool_full;
  } exec_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/rrgtq_req_if.sv @@
// Request channel: push or pop transactions into the queue.
// Depends on rrgtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rrgtq_req_if import rrgtq_pkg::*; ();
  logic                valid;
  logic                ready;
  act_e                action;
  logic [GROUP_W-1:0]  group_id;
  logic [TASK_W-1:0]   task_tag;

  modport source (output valid, action, group_id, task_tag, input ready);
  modport sink   (input valid, action, group_id, task_tag, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rrgtq_rsp_if.sv @@
// Response channel: one status transaction per request.
// Depends on rrgtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rrgtq_rsp_if import rrgtq_pkg::*; ();
  logic                valid;
  logic                ready;
  status_e             status;
  logic [GROUP_W-1:0]  served_group;
  logic [TASK_W-1:0]   served_task;

  modport source (output valid, status, served_group, served_task, input ready);
  modport sink   (input valid, status, served_group, served_task, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rrgtq_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on rrgtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rrgtq_cfg_if import rrgtq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [MAX_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rrgtq_slot_mem.sv @@
// Slot pool storage: task tag memory and slot link memory, registered reads.
// Depends on rrgtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrgtq_slot_mem import rrgtq_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int STORE_W = TAG_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire mem_ctl_t                 ctl_i,
  input  wire logic [$clog2(SLOTS)-1:0] tag_addr_i,
  input  wire logic [STORE_W-1:0]       tag_wd_i,
  input  wire logic [$clog2(SLOTS)-1:0] nx_wa_i,
  input  wire logic [$clog2(SLOTS)-1:0] nx_wd_i,
  input  wire logic [$clog2(SLOTS)-1:0] nx_ra_i,
  output logic      [STORE_W-1:0]       tag_rd_o,
  output logic      [$clog2(SLOTS)-1:0] nx_rd_o
);

  localparam int SW = $clog2(SLOTS);

  logic [STORE_W-1:0] tag_mem [SLOTS];
  logic [SW-1:0]      nx_mem  [SLOTS];
  logic [STORE_W-1:0] tag_rd_q;
  logic [SW-1:0]      nx_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.tag_we) begin
      tag_mem[tag_addr_i] <= tag_wd_i;
    end
    if (ctl_i.tag_re) begin
      tag_rd_q <= tag_mem[tag_addr_i];
    end
  end

  // read returns the old word when the same address is written
  always_ff @(posedge clk_i) begin
    if (ctl_i.nx_we) begin
      nx_mem[nx_wa_i] <= nx_wd_i;
    end
    if (ctl_i.nx_re) begin
      nx_rd_q <= nx_mem[nx_ra_i];
    end
  end

  assign tag_rd_o = tag_rd_q;
  assign nx_rd_o  = nx_rd_q;

endmodule

`default_nettype wire

@@ rtl/core/rrgtq_exec.sv @@
// Queue control: group pointers, rotation ring, free list and counters.
// Decides each transaction combinationally; depends on rrgtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrgtq_exec import rrgtq_pkg::*; #(
  parameter int GROUPS = GROUPS_DEF,
  parameter int SLOTS  = SLOTS_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    fire_i,
  input  wire act_e                                    action_i,
  input  wire logic [GROUP_W-1:0]                      group_id_i,
  input  wire logic [MAX_W-1:0]                        max_tasks_i,
  input  wire logic                                    closed_i,
  input  wire logic [$clog2(SLOTS)-1:0]                nx_rd_i,
  output status_e                                      status_o,
  output logic      [((GROUPS > 1) ? $clog2(GROUPS) : 1)-1:0] group_o,
  output mem_ctl_t                                     mem_ctl_o,
  output logic      [$clog2(SLOTS)-1:0]                slot_o,
  output logic      [$clog2(SLOTS)-1:0]                nx_wa_o,
  output logic      [$clog2(SLOTS)-1:0]                nx_wd_o,
  output logic      [$clog2(SLOTS)-1:0]                nx_ra_o,
  output exec_stat_t                                   stat_o
);

  localparam int GW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CW   = $clog2(GROUPS + 1);
  localparam int SW   = $clog2(SLOTS);
  localparam int TW   = $clog2(SLOTS + 1);
  localparam int CMPW = (TW > MAX_W) ? TW : MAX_W;
  localparam int RW   = ((GW > CW) ? GW : CW) + 1;

  logic [SW-1:0]     head_q [GROUPS];
  logic [SW-1:0]     tail_q [GROUPS];
  logic [GW-1:0]     ring_q [GROUPS];
  logic [GROUPS-1:0] active_q;
  logic [GW-1:0]     front_q;
  logic [CW-1:0]     count_q;
  logic [TW-1:0]     total_q;
  logic [TW-1:0]     fresh_q;
  logic [SW-1:0]     free_head_q;
  logic              pend_grp_q;
  logic              pend_free_q;
  logic [GW-1:0]     pend_g_q;

  logic [GROUP_W-1:0] gm;
  logic [GW-1:0]      g_push;
  logic [GW-1:0]      g_pop;
  logic [SW-1:0]      pop_slot;
  logic [SW-1:0]      eff_free;
  logic [SW-1:0]      alloc;
  logic               drained;
  logic               fresh_left;
  logic               limit;
  logic               pool_full;
  logic               q_empty;
  logic               push_ok;
  logic               pop_ok;
  logic [RW-1:0]      rsum;
  logic [GW-1:0]      ring_wa;
  logic [GW-1:0]      front_nx;
  status_e            status;

  // group id folded into range by repeated subtraction
  always_comb begin
    gm = group_id_i;
    for (int i = 0; i < 8; i++) begin
      if (int'(gm) >= GROUPS) begin
        gm = gm - GROUP_W'(GROUPS);
      end
    end
  end

  assign g_push = GW'(gm);
  assign g_pop  = ring_q[front_q];

  // slot link read of the previous cycle is forwarded until committed
  assign pop_slot = (pend_grp_q && (pend_g_q == g_pop)) ? nx_rd_i : head_q[g_pop];
  assign eff_free = pend_free_q ? nx_rd_i : free_head_q;
  assign drained  = (pop_slot == tail_q[g_pop]);

  assign fresh_left = (fresh_q != TW'(SLOTS));
  assign alloc      = fresh_left ? fresh_q[SW-1:0] : eff_free;
  assign limit      = (CMPW'(total_q) >= CMPW'(max_tasks_i));
  assign pool_full  = (total_q == TW'(SLOTS));
  assign q_empty    = (count_q == '0);

  assign rsum     = RW'(front_q) + RW'(count_q);
  assign ring_wa  = (rsum >= RW'(GROUPS)) ? GW'(rsum - RW'(GROUPS)) : GW'(rsum);
  assign front_nx = (front_q == GW'(GROUPS - 1)) ? '0 : front_q + 1'b1;

  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    status  = ST_OK;
    case (action_i)
      ACT_POP: begin
        if (q_empty) begin
          status = ST_EMPTY;
        end else begin
          pop_ok = 1'b1;
        end
      end
      ACT_PUSH: begin
        if (closed_i) begin
          status = ST_CLOSED;
        end else if ((active_q[g_push] && limit) || pool_full) begin
          status = ST_FULL;
        end else begin
          push_ok = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    mem_ctl_o.tag_we = fire_i && push_ok;
    mem_ctl_o.tag_re = fire_i && pop_ok;
    mem_ctl_o.nx_we  = fire_i && (pop_ok || (push_ok && active_q[g_push]));
    mem_ctl_o.nx_re  = fire_i && ((pop_ok && !drained) || (push_ok && !fresh_left));
    slot_o           = pop_ok ? pop_slot : alloc;
    nx_wa_o          = pop_ok ? pop_slot : tail_q[g_push];
    nx_wd_o          = pop_ok ? eff_free : alloc;
    nx_ra_o          = pop_ok ? pop_slot : eff_free;
  end

  assign status_o         = status;
  assign group_o          = g_pop;
  assign stat_o.q_empty   = q_empty;
  assign stat_o.pool_full = pool_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      total_q     <= '0;
      fresh_q     <= '0;
      active_q    <= '0;
      pend_grp_q  <= 1'b0;
      pend_free_q <= 1'b0;
    end else begin
      pend_grp_q  <= fire_i && pop_ok && !drained;
      pend_free_q <= fire_i && push_ok && !fresh_left;
      if (fire_i && pop_ok) begin
        front_q <= front_nx;
        total_q <= total_q - 1'b1;
        if (drained) begin
          active_q[g_pop] <= 1'b0;
          count_q         <= count_q - 1'b1;
        end
      end
      if (fire_i && push_ok) begin
        total_q <= total_q + 1'b1;
        if (fresh_left) begin
          fresh_q <= fresh_q + 1'b1;
        end
        if (!active_q[g_push]) begin
          active_q[g_push] <= 1'b1;
          count_q          <= count_q + 1'b1;
        end
      end
    end
  end

  // pointer payload; the current transaction overrides a pending commit
  always_ff @(posedge clk_i) begin
    if (pend_grp_q) begin
      head_q[pend_g_q] <= nx_rd_i;
    end
    if (fire_i && pop_ok) begin
      free_head_q <= pop_slot;
      pend_g_q    <= g_pop;
      if (!drained) begin
        ring_q[ring_wa] <= g_pop;
      end
    end else if (pend_free_q) begin
      free_head_q <= nx_rd_i;
    end
    if (fire_i && push_ok) begin
      tail_q[g_push] <= alloc;
      if (!active_q[g_push]) begin
        head_q[g_push]  <= alloc;
        ring_q[ring_wa] <= g_push;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/round_robin_group_task_queue.sv @@
// Round-robin group task queue: one task FIFO per group, served in rotation.
// Top level; depends on rrgtq_pkg, the channel interfaces, rrgtq_exec and rrgtq_slot_mem.
//
// Push and pop requests arrive on req_i and each produces exactly one response
// on rsp_o. A request is held in the input register and decided by the pointer
// logic once the response register is free or being read; the decision lands
// in the response register, which drives rsp_o. One request per clock cycle
// is sustained while responses are taken: the registered read of the slot
// link memory is forwarded into the next cycle's decision. A stalled response
// holds the decision stage; the input register takes a request only when empty.
// Tasks share a pool of SLOTS linked slots; the memories need no clearing after
// reset, so requests are taken right away. Configuration writes on cfg_i are
// always ready and must only be issued while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_group_task_queue_defines.svh"

module round_robin_group_task_queue import rrgtq_pkg::*; #(
  parameter int GROUPS   = GROUPS_DEF,
  parameter int SLOTS    = SLOTS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rrgtq_req_if.sink   req_i,
  rrgtq_rsp_if.source rsp_o,
  rrgtq_cfg_if.sink   cfg_i
);

  localparam int GW      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SW      = $clog2(SLOTS);
  localparam int STORE_W = (TAG_BITS < TASK_W) ? TAG_BITS : TASK_W;

  logic                in_vld_q;
  act_e                in_act_q;
  logic [GROUP_W-1:0]  in_grp_q;
  logic [STORE_W-1:0]  in_tag_q;

  logic                res_vld_q;
  status_e             res_status_q;
  logic [GROUP_W-1:0]  res_grp_q;
  logic                res_served_q;

  logic [MAX_W-1:0]    max_tasks_q;
  logic                closed_q;

  logic                fire;
  logic                pop_fire;
  logic                push_fire;
  status_e             ex_status;
  logic [GW-1:0]       ex_group;
  mem_ctl_t            mem_ctl;
  exec_stat_t          stat;
  logic [SW-1:0]       slot;
  logic [SW-1:0]       nx_wa;
  logic [SW-1:0]       nx_wd;
  logic [SW-1:0]       nx_ra;
  logic [SW-1:0]       nx_rd;
  logic [STORE_W-1:0]  tag_rd;
  logic                served;

  assign fire        = in_vld_q && (!res_vld_q || rsp_o.ready);
  assign pop_fire    = fire && (in_act_q == ACT_POP);
  assign push_fire   = fire && (in_act_q == ACT_PUSH);
  assign req_i.ready = !in_vld_q || fire;
  assign cfg_i.ready = 1'b1;
  assign served      = (in_act_q == ACT_POP) && (ex_status == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_act_q <= req_i.action;
      in_grp_q <= req_i.group_id;
      in_tag_q <= req_i.task_tag[STORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (fire) begin
      res_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_status_q <= ex_status;
      res_grp_q    <= served ? GROUP_W'(ex_group) : '0;
      res_served_q <= served;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tasks_q <= MAX_TASKS_RST;
      closed_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_MAX_TASKS:    max_tasks_q <= cfg_i.data;
        REG_QUEUE_CLOSED: closed_q    <= cfg_i.data[0];
        default: begin
          closed_q <= closed_q;
        end
      endcase
    end
  end

  rrgtq_exec #(
    .GROUPS (GROUPS),
    .SLOTS  (SLOTS)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .action_i    (in_act_q),
    .group_id_i  (in_grp_q),
    .max_tasks_i (max_tasks_q),
    .closed_i    (closed_q),
    .nx_rd_i     (nx_rd),
    .status_o    (ex_status),
    .group_o     (ex_group),
    .mem_ctl_o   (mem_ctl),
    .slot_o      (slot),
    .nx_wa_o     (nx_wa),
    .nx_wd_o     (nx_wd),
    .nx_ra_o     (nx_ra),
    .stat_o      (stat)
  );

  rrgtq_slot_mem #(
    .SLOTS   (SLOTS),
    .STORE_W (STORE_W)
  ) u_slot_mem (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .tag_addr_i (slot),
    .tag_wd_i   (in_tag_q),
    .nx_wa_i    (nx_wa),
    .nx_wd_i    (nx_wd),
    .nx_ra_i    (nx_ra),
    .tag_rd_o   (tag_rd),
    .nx_rd_o    (nx_rd)
  );

  assign rsp_o.valid        = res_vld_q;
  assign rsp_o.status       = res_status_q;
  assign rsp_o.served_group = res_grp_q;
  assign rsp_o.served_task  = res_served_q ? TASK_W'(tag_rd) : '0;

  `RRGTQ_ASSERT_NEXT(a_empty, pop_fire && stat.q_empty, res_status_q == ST_EMPTY, "empty pop")
  `RRGTQ_ASSERT_NEXT(a_closed, push_fire && closed_q, res_status_q == ST_CLOSED, "closed push")
  `RRGTQ_ASSERT_NEXT(a_pool, push_fire && stat.pool_full, res_status_q != ST_OK, "pool overrun")
  `RRGTQ_ASSERT(a_served, !res_vld_q || !res_served_q || (res_status_q == ST_OK), "served flag")

endmodule

`default_nettype wire

@@ tb/rrgtq_checker.sv @@
// Scoreboard for the round-robin group task queue: mirrors queue state from the
// observed request and config transactions and checks every response.
// Depends on rrgtq_pkg and the req/rsp/cfg channel interfaces.
`timescale 1ns / 1ps

module rrgtq_checker import rrgtq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrgtq_req_if        req_i,
  rrgtq_rsp_if        rsp_i,
  rrgtq_cfg_if        cfg_i,
  output int unsigned failures_o,
  output int unsigned backlog_o
);

  localparam int NGROUPS    = 16;
  localparam int NSLOTS     = 64;
  localparam int FIFO_DEPTH = 64;

  typedef struct packed {
    status_e            st;
    logic [GROUP_W-1:0] grp;
    logic [TASK_W-1:0]  tag;
  } outcome_t;

  logic [TASK_W-1:0]  slot_tag  [NSLOTS];
  logic [5:0]         slot_link [NSLOTS];
  logic               slot_free [NSLOTS];
  logic [5:0]         grp_head  [NGROUPS];
  logic [5:0]         grp_tail  [NGROUPS];
  logic               grp_active[NGROUPS];
  logic [GROUP_W-1:0] ring      [NGROUPS];
  logic [3:0]         ring_front;
  logic [4:0]         ring_count;
  logic [6:0]         queued;
  logic [MAX_W-1:0]   task_limit;
  logic               closed;

  outcome_t           want_fifo [FIFO_DEPTH];
  logic [5:0]         fifo_rd;
  logic [5:0]         fifo_wr;
  int unsigned        fifo_cnt;

  function automatic void ring_push(logic [GROUP_W-1:0] g);
    ring[ring_front + ring_count[3:0]] = g;
    ring_count++;
  endfunction

  function automatic outcome_t schedule_request(act_e act, logic [GROUP_W-1:0] g_in,
                                                logic [TASK_W-1:0] tag_in);
    outcome_t           o;
    logic [GROUP_W-1:0] g;
    logic [5:0]         s;
    int                 found;
    o = '{st: ST_OK, grp: '0, tag: '0};
    found = -1;
    if (act == ACT_POP) begin
      if (ring_count == 0) begin
        o.st = ST_EMPTY;
      end else begin
        g = ring[ring_front];
        ring_front++;
        ring_count--;
        s = grp_head[g];
        o.grp = g;
        o.tag = slot_tag[s];
        slot_free[s] = 1'b1;
        if (queued > 0) queued--;
        if (s == grp_tail[g]) begin
          grp_active[g] = 1'b0;
        end else begin
          grp_head[g] = slot_link[s];
          ring_push(g);
        end
      end
    end else if (closed) begin
      o.st = ST_CLOSED;
    end else if (grp_active[g_in] && queued >= task_limit) begin
      o.st = ST_FULL;
    end else begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (slot_free[i] && found < 0) found = i;
      end
      if (found < 0) begin
        o.st = ST_FULL;
      end else begin
        s = 6'(found);
        slot_free[s] = 1'b0;
        slot_tag[s] = tag_in;
        if (grp_active[g_in]) begin
          slot_link[grp_tail[g_in]] = s;
          grp_tail[g_in] = s;
        end else begin
          grp_head[g_in] = s;
          grp_tail[g_in] = s;
          grp_active[g_in] = 1'b1;
          ring_push(g_in);
        end
        queued++;
      end
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NSLOTS; i++) slot_free[i] = 1'b1;
      for (int i = 0; i < NGROUPS; i++) grp_active[i] = 1'b0;
      ring_front = '0;
      ring_count = '0;
      queued     = '0;
      task_limit = MAX_TASKS_RST;
      closed     = 1'b0;
      fifo_rd    = '0;
      fifo_wr    = '0;
      fifo_cnt   = 0;
      failures_o = 0;
      backlog_o  = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_MAX_TASKS:    task_limit = cfg_i.data;
          REG_QUEUE_CLOSED: closed     = cfg_i.data[0];
          default: ;
        endcase
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (fifo_cnt == 0) begin
          failures_o++;
          if (failures_o <= 10)
            $display("%0t: response with nothing outstanding: st=%0d grp=%0d tag=%h",
                     $realtime, rsp_i.status, rsp_i.served_group, rsp_i.served_task);
        end else begin
          want = want_fifo[fifo_rd];
          fifo_rd++;
          fifo_cnt--;
          if (rsp_i.status !== want.st || rsp_i.served_group !== want.grp ||
              rsp_i.served_task !== want.tag) begin
            failures_o++;
            if (failures_o <= 10)
              $display("%0t: mismatch exp st=%0d grp=%0d tag=%h got st=%0d grp=%0d tag=%h",
                       $realtime, want.st, want.grp, want.tag, rsp_i.status,
                       rsp_i.served_group, rsp_i.served_task);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        want = schedule_request(req_i.action, req_i.group_id, req_i.task_tag);
        if (fifo_cnt == FIFO_DEPTH) begin
          failures_o++;
          if (failures_o <= 10)
            $display("%0t: too many requests without a response", $realtime);
        end else begin
          want_fifo[fifo_wr] = want;
          fifo_wr++;
          fifo_cnt++;
        end
      end
      backlog_o = fifo_cnt;
    end
  end

endmodule

@@ tb/testbench.sv @@
// Top of the task queue testbench: clock, reset, stimulus and verdict.
// Depends on rrgtq_pkg, the channel interfaces, rrgtq_checker and the DUT.
`timescale 1ns / 1ps

module testbench;
  import rrgtq_pkg::*;

  logic        clk;
  logic        rst_n;
  int unsigned failures;
  int unsigned backlog;
  int unsigned req_sent;
  int unsigned rsp_seen;
  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_armed;

  rrgtq_req_if req_if ();
  rrgtq_rsp_if rsp_if ();
  rrgtq_cfg_if cfg_if ();

  round_robin_group_task_queue dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  rrgtq_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .rsp_i      (rsp_if),
    .cfg_i      (cfg_if),
    .failures_o (failures),
    .backlog_o  (backlog)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Response side: random backpressure, plus one long hold-off when armed.
  initial begin
    bit          hold_done;
    int unsigned hold_left;
    hold_done = 1'b0;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) rsp_seen++;
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic set_mode(int unsigned m);
    case (m % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 67; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 67; end
      default: begin idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  task automatic send_req(act_e act, logic [GROUP_W-1:0] grp, logic [TASK_W-1:0] tag);
    if (idle_pct != 0) begin
      while ($urandom_range(99) < idle_pct) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= act;
    req_if.group_id <= grp;
    req_if.task_tag <= tag;
    do @(posedge clk); while (!req_if.ready);
    req_sent++;
  endtask

  task automatic push_task(logic [GROUP_W-1:0] grp, logic [TASK_W-1:0] tag);
    send_req(ACT_PUSH, grp, tag);
  endtask

  task automatic pop_task();
    send_req(ACT_POP, GROUP_W'($urandom_range(15)), $urandom());
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (rsp_seen != req_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [MAX_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int                 limits[12];
    int unsigned        spans[4];
    int unsigned        push_pct;
    int unsigned        span;
    logic [MAX_W-1:0]   lim;
    logic [GROUP_W-1:0] grp;

    limits     = '{63, 1, 48, 0, -1, 17, 63, 1, -1, 48, 2, -1};
    spans      = '{15, 3, 1, 7};
    req_sent   = 0;
    rsp_seen   = 0;
    hold_armed = 1'b0;
    set_mode(0);
    req_if.valid    = 1'b0;
    req_if.action   = ACT_PUSH;
    req_if.group_id = '0;
    req_if.task_tag = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_MAX_TASKS;
    cfg_if.data     = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, extreme groups and tags, rotation order.
    pop_task();
    push_task(4'd0, 32'h0000_0000);
    push_task(4'd15, 32'hFFFF_FFFF);
    push_task(4'd0, 32'hA5A5_A5A5);
    push_task(4'd7, 32'h5A5A_5A5A);
    repeat (5) pop_task();
    push_task(4'd1, 32'h0000_0001);
    push_task(4'd2, 32'h8000_0000);
    wait_drained();

    // Closed queue refuses pushes but still drains, then reports empty.
    write_reg(REG_QUEUE_CLOSED, 6'd1);
    push_task(4'd1, 32'h1234_5678);
    push_task(4'd9, 32'h0F0F_0F0F);
    repeat (3) pop_task();
    wait_drained();

    // Zero limit: only admission bypass pushes get in.
    write_reg(REG_QUEUE_CLOSED, 6'd0);
    write_reg(REG_MAX_TASKS, 6'd0);
    push_task(4'd4, 32'hDEAD_BEEF);
    push_task(4'd4, 32'hCAFE_F00D);
    push_task(4'd9, 32'h7FFF_FFFF);
    repeat (3) pop_task();
    wait_drained();

    // Random phases across limits, open/closed and flow-control modes.
    for (int p = 0; p < 12; p++) begin
      lim = (limits[p] < 0) ? MAX_W'($urandom_range(1, 48)) : MAX_W'(limits[p]);
      write_reg(REG_MAX_TASKS, lim);
      write_reg(REG_QUEUE_CLOSED, (p == 5 || p == 10) ? 6'd1 : 6'd0);
      set_mode(p);
      push_pct = $urandom_range(35, 75);
      span     = spans[p % 4];
      for (int n = 0; n < 85; n++) begin
        grp = ($urandom_range(7) == 0) ? GROUP_W'($urandom_range(15))
                                       : GROUP_W'($urandom_range(span));
        if ($urandom_range(99) < push_pct) push_task(grp, $urandom());
        else pop_task();
      end
      wait_drained();
    end

    // Pool exhaustion with a long response hold-off to back up the input.
    write_reg(REG_MAX_TASKS, 6'd63);
    write_reg(REG_QUEUE_CLOSED, 6'd0);
    set_mode(0);
    repeat (70) pop_task();
    wait_drained();
    hold_armed = 1'b1;
    repeat (63) push_task(GROUP_W'($urandom_range(13)), $urandom());
    push_task(4'd14, $urandom());
    push_task(4'd15, $urandom());
    push_task(4'd0, $urandom());
    set_mode(3);
    repeat (70) pop_task();
    wait_drained();

    if (failures == 0 && backlog == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
